// ===== src/assert_macros.svh =====
// assertion helpers used by the core rtl file
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define BRS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define BRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/brs_pkg.sv =====
// types, codes and defaults of the button remap sequencer
// no dependencies; used by the channel interfaces and the core
package brs_pkg;

    localparam int OP_W   = 2;
    localparam int PAD_W  = 12;
    localparam int CODE_W = 3;
    localparam int MAP_W  = 18;
    localparam int DEB_W  = 16;

    localparam int SLOT_COUNT_DEF    = 6;
    localparam int PRIMARY_SLOTS_DEF = 3;
    localparam int FACE_COUNT        = 6;
    localparam int MIRROR_OFFSET     = 3;
    localparam int MAP_SLOTS_SHOWN   = MAP_W / CODE_W;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [PAD_W-1:0]  t_pad;
    typedef logic [CODE_W-1:0] t_code;
    typedef logic [MAP_W-1:0]  t_map_word;
    typedef logic [DEB_W-1:0]  t_deb;

    localparam t_op OP_TICK        = 2'd0;
    localparam t_op OP_PAD         = 2'd1;
    localparam t_op OP_START_FULL  = 2'd2;
    localparam t_op OP_START_THREE = 2'd3;

    localparam t_code BTN_NONE = 3'd0;
    localparam t_code BTN_C    = 3'd3;

    localparam t_deb DEBOUNCE_RESET = 16'd200;

    typedef struct packed {
        logic      active;
        logic      three_button_mode;
        logic      accepted;
        t_code     slot_index;
        t_code     button_code;
        logic      finished;
        t_map_word map_word;
    } t_result;

endpackage

// ===== src/brs_channels.sv =====
// valid/ready channel interfaces of the button remap sequencer
// depends on brs_pkg
interface brs_in_if;
    import brs_pkg::*;
    logic valid;
    logic ready;
    t_op  op;
    t_pad pad_buttons;
    modport source (output valid, output op, output pad_buttons, input ready);
    modport sink (input valid, input op, input pad_buttons, output ready);
endinterface

interface brs_out_if;
    import brs_pkg::*;
    logic      valid;
    logic      ready;
    logic      active;
    logic      three_button_mode;
    logic      accepted;
    t_code     slot_index;
    t_code     button_code;
    logic      finished;
    t_map_word map_word;
    modport source (
        output valid, output active, output three_button_mode, output accepted,
        output slot_index, output button_code, output finished, output map_word,
        input ready
    );
    modport sink (
        input valid, input active, input three_button_mode, input accepted,
        input slot_index, input button_code, input finished, input map_word,
        output ready
    );
endinterface

interface brs_cfg_if;
    import brs_pkg::*;
    logic valid;
    logic ready;
    t_deb data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/button_remap_sequencer_core.sv =====
// button remap sequencer: session control, slot map and result register
// depends on brs_pkg, brs_channels and assert_macros.svh
//
// usage:
//   i_in   beats carry op and pad_buttons: tick, pad sample, start full remap,
//          start three-button remap. every beat yields exactly one result beat.
//   o_out  result beats: session flags, the assignment made (if any) and the
//          packed slot map after the beat.
//   i_cfg  write beats set the debounce tick count; always ready; the user must
//          write it only while the block is idle, which the block does not enforce.
// results are registered: the output register loads a beat's result when the beat is taken.
// throughput: one beat per cycle while o_out.ready is held high; the session state and the slot map update
//   in the cycle a beat is taken, so the next beat may follow at once.
// stall: i_in.ready follows the output register; it stays high while the
//   register is empty or being drained, so input and output advance together.
// reset: synchronous; the map clears, the session ends, the debounce count
//   returns to zero and the tick count to 200.
module button_remap_sequencer_core #(
    parameter int SLOT_COUNT    = brs_pkg::SLOT_COUNT_DEF,
    parameter int PRIMARY_SLOTS = brs_pkg::PRIMARY_SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    brs_in_if.sink        i_in,
    brs_out_if.source     o_out,
    brs_cfg_if.sink       i_cfg
);
    import brs_pkg::*;
    `include "assert_macros.svh"

    localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
    localparam int PRIMARY = (PRIMARY_SLOTS < SLOT_COUNT) ? PRIMARY_SLOTS : SLOT_COUNT;
    localparam int SHOWN   = (SLOT_COUNT < MAP_SLOTS_SHOWN) ? SLOT_COUNT : MAP_SLOTS_SHOWN;
    localparam logic [CNT_W-1:0] PRIMARY_CNT = CNT_W'(PRIMARY);
    localparam logic [CNT_W-1:0] SLOT_CNT    = CNT_W'(SLOT_COUNT);

    t_deb              r_debounce_ticks;
    t_code             r_slot_map [SLOT_COUNT];
    t_code             n_slot_map [SLOT_COUNT];
    logic [SLOT_W-1:0] r_next_slot, n_next_slot;
    logic              r_active, n_active;
    logic              r_three, n_three;
    t_deb              r_debounce_left, n_debounce_left;
    logic              r_out_valid;
    t_result           r_res, n_res;

    logic              in_beat;
    t_code             face;
    logic              dup;
    logic              take;
    logic [CNT_W-1:0]  check_cnt;
    logic [CNT_W-1:0]  slot_plus;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_beat     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= DEBOUNCE_RESET;
        end else if (i_cfg.valid) begin
            r_debounce_ticks <= i_cfg.data;
        end
    end

    // decode the pad word: exactly one face bit, X/Y/Z refused in three-button mode
    always_comb begin
        face = BTN_NONE;
        for (int k = 0; k < FACE_COUNT; k++) begin
            if (i_in.pad_buttons == (t_pad'(1) << k)) begin
                face = CODE_W'(k + 1);
            end
        end
        if (r_three && face > BTN_C) begin
            face = BTN_NONE;
        end
    end

    always_comb begin
        check_cnt = r_three ? PRIMARY_CNT : CNT_W'(r_next_slot);
        dup = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (CNT_W'(i) < check_cnt && r_slot_map[i] == face) begin
                dup = 1'b1;
            end
        end
    end

    assign take      = (i_in.op == OP_PAD) && r_active && (r_debounce_left == '0)
                       && (face != BTN_NONE) && !dup
                       && (CNT_W'(r_next_slot) < SLOT_CNT);
    assign slot_plus = CNT_W'(r_next_slot) + CNT_W'(1);

    always_comb begin
        n_slot_map      = r_slot_map;
        n_next_slot     = r_next_slot;
        n_active        = r_active;
        n_three         = r_three;
        n_debounce_left = r_debounce_left;
        n_res           = '0;

        unique case (i_in.op)
            OP_TICK: begin
                if (r_debounce_left != '0) begin
                    n_debounce_left = r_debounce_left - t_deb'(1);
                end
            end
            OP_PAD: begin
                if (take) begin
                    n_res.accepted    = 1'b1;
                    n_res.slot_index  = CODE_W'(r_next_slot);
                    n_res.button_code = face;
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (i == int'(r_next_slot)) begin
                            n_slot_map[i] = face;
                        end
                        // three-button mode mirrors A/B/C as X/Y/Z further up
                        if (r_three && face <= BTN_C
                                && i == int'(r_next_slot) + MIRROR_OFFSET) begin
                            n_slot_map[i] = face + CODE_W'(MIRROR_OFFSET);
                        end
                    end
                    if (slot_plus >= (r_three ? PRIMARY_CNT : SLOT_CNT)) begin
                        n_res.finished = 1'b1;
                        n_active       = 1'b0;
                        n_three        = 1'b0;
                        n_next_slot    = '0;
                    end else begin
                        n_next_slot     = SLOT_W'(slot_plus);
                        n_debounce_left = r_debounce_ticks;
                    end
                end
            end
            OP_START_FULL, OP_START_THREE: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    n_slot_map[i] = BTN_NONE;
                end
                n_next_slot     = '0;
                n_active        = 1'b1;
                n_three         = (i_in.op == OP_START_THREE);
                n_debounce_left = '0;
            end
            default: ;
        endcase

        n_res.active            = n_active;
        n_res.three_button_mode = n_three;
        for (int i = 0; i < SHOWN; i++) begin
            n_res.map_word[i*CODE_W +: CODE_W] = n_slot_map[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot_map[i] <= BTN_NONE;
            end
            r_next_slot     <= '0;
            r_active        <= 1'b0;
            r_three         <= 1'b0;
            r_debounce_left <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (in_beat) begin
                r_slot_map      <= n_slot_map;
                r_next_slot     <= n_next_slot;
                r_active        <= n_active;
                r_three         <= n_three;
                r_debounce_left <= n_debounce_left;
                r_out_valid     <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.active            = r_res.active;
    assign o_out.three_button_mode = r_res.three_button_mode;
    assign o_out.accepted          = r_res.accepted;
    assign o_out.slot_index        = r_res.slot_index;
    assign o_out.button_code       = r_res.button_code;
    assign o_out.finished          = r_res.finished;
    assign o_out.map_word          = r_res.map_word;

    `BRS_ASSERT(a_debounce_in_session, i_clk, i_rst_n, (r_debounce_left != '0) |-> r_active, "debounce running outside a session")
    `BRS_ASSERT(a_idle_clean, i_clk, i_rst_n, !r_active |-> (r_next_slot == '0 && !r_three), "idle state not cleared")
    `BRS_ASSERT(a_slot_range, i_clk, i_rst_n, CNT_W'(r_next_slot) < SLOT_CNT, "next slot beyond the map")
    `BRS_ASSERT(a_finish_ends, i_clk, i_rst_n, (r_out_valid && r_res.finished) |-> (r_res.accepted && !r_res.active), "finish without closing the session")
    `BRS_ASSERT(a_accept_code, i_clk, i_rst_n, (r_out_valid && r_res.accepted) |-> (r_res.button_code != BTN_NONE), "assignment without a button")

endmodule

// ===== tb/tb.sv =====
// self-checking bench for button_remap_sequencer_core: scripted and random beats on the
// input and config channels, results checked against an in-bench model of the remap session
// depends on brs_pkg, the channel interfaces in brs_channels and button_remap_sequencer_core
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brs_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 3;
    localparam int PRINT_CAP     = 200;
    localparam int HOLD_CYCLES   = 60;
    localparam int PHASE_BEATS   = 290;
    localparam int PRIMARY_USED  =
        (PRIMARY_SLOTS_DEF < SLOT_COUNT_DEF) ? PRIMARY_SLOTS_DEF : SLOT_COUNT_DEF;

    typedef enum logic [1:0] {
        SCRIPT_BEAT,
        SCRIPT_CFG,
        SCRIPT_DRAIN
    } t_script_kind;

    typedef struct {
        t_script_kind kind;
        t_op          op;
        t_pad         pad;
        t_deb         value;
    } t_script_entry;

    logic i_clk = 1'b0;
    logic i_rst_n;

    brs_in_if  in_ch ();
    brs_out_if out_ch ();
    brs_cfg_if cfg_ch ();

    button_remap_sequencer_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // session model
    t_code      slot_map [SLOT_COUNT_DEF];
    logic [2:0] next_slot;
    logic       sess_on;
    logic       three_on;
    t_deb       deb_left;
    t_deb       deb_ticks;

    t_script_entry beat_script[$];
    t_result       predicted_beats[$];

    int beats_queued;
    int beats_sent;
    int results_seen;
    int settings_done;
    int assigned_cnt;
    int sessions_done;
    int errors;
    int cycle_cnt;
    logic script_done = 1'b0;

    function automatic t_result remap_step(t_op op, t_pad pad);
        t_result r;
        t_code   btn;
        logic    taken;
        int      check_n;
        int      need_n;
        int      i;
        r = '0;
        btn = BTN_NONE;
        taken = 1'b0;
        case (op)
            OP_TICK: if (deb_left != '0) deb_left = deb_left - t_deb'(1);
            OP_START_FULL, OP_START_THREE: begin
                for (i = 0; i < SLOT_COUNT_DEF; i++) slot_map[i] = BTN_NONE;
                next_slot = '0;
                sess_on = 1'b1;
                three_on = (op == OP_START_THREE);
                deb_left = '0;
            end
            OP_PAD: if (sess_on && deb_left == '0) begin
                // the whole pad word must be a single face button
                for (i = 0; i < FACE_COUNT; i++)
                    if (pad == (t_pad'(1) << i)) btn = t_code'(i + 1);
                if (three_on && btn > BTN_C) btn = BTN_NONE;
                check_n = three_on ? PRIMARY_USED : int'(next_slot);
                for (i = 0; i < check_n && i < SLOT_COUNT_DEF; i++)
                    if (slot_map[i] == btn) taken = 1'b1;
                if (btn != BTN_NONE && !taken && next_slot < SLOT_COUNT_DEF) begin
                    need_n = three_on ? PRIMARY_USED : SLOT_COUNT_DEF;
                    r.accepted = 1'b1;
                    r.slot_index = next_slot;
                    r.button_code = btn;
                    slot_map[next_slot] = btn;
                    // a/b/c also land as x/y/z in the mirror slot, dropped past the map
                    if (three_on && btn <= BTN_C &&
                        int'(next_slot) + MIRROR_OFFSET < SLOT_COUNT_DEF)
                        slot_map[int'(next_slot) + MIRROR_OFFSET] = btn + t_code'(MIRROR_OFFSET);
                    next_slot = next_slot + 3'd1;
                    assigned_cnt++;
                    if (int'(next_slot) >= need_n) begin
                        r.finished = 1'b1;
                        sess_on = 1'b0;
                        three_on = 1'b0;
                        next_slot = '0;
                        sessions_done++;
                    end else begin
                        deb_left = deb_ticks;
                    end
                end
            end
        endcase
        r.active = sess_on;
        r.three_button_mode = three_on;
        for (i = 0; i < SLOT_COUNT_DEF && i < MAP_SLOTS_SHOWN; i++)
            r.map_word[CODE_W*i +: CODE_W] = slot_map[i];
        return r;
    endfunction

    task automatic report(string msg);
        errors++;
        if (errors <= PRINT_CAP) $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, int got, int want);
        if (got !== want)
            report($sformatf("result %0d %s: got %0h expected %0h",
                             results_seen, name, got, want));
    endtask

    // script building
    function automatic void push_beat(t_op op, t_pad pad);
        t_script_entry e;
        e = '{kind: SCRIPT_BEAT, op: op, pad: pad, value: '0};
        beat_script.push_back(e);
        beats_queued++;
    endfunction

    function automatic void push_setting(t_deb v);
        t_script_entry e;
        e = '{kind: SCRIPT_DRAIN, op: OP_TICK, pad: '0, value: '0};
        beat_script.push_back(e);
        e.kind = SCRIPT_CFG;
        e.value = v;
        beat_script.push_back(e);
    endfunction

    function automatic void push_noise();
        case ($urandom_range(0, 3))
            0: push_beat(t_op'($urandom_range(0, 3)), t_pad'($urandom_range(0, 4095)));
            1: push_beat(OP_PAD, t_pad'(1) << $urandom_range(0, FACE_COUNT - 1));
            2: push_beat(OP_PAD, (t_pad'(1) << $urandom_range(0, FACE_COUNT - 1)) |
                                 (t_pad'($urandom_range(1, 63)) << FACE_COUNT));
            default: push_beat(OP_TICK, t_pad'($urandom_range(0, 4095)));
        endcase
    endfunction

    // one remap session, mostly well formed, with noise mixed in
    function automatic void queue_session(int deb);
        logic       three;
        logic [5:0] used;
        int         faces;
        int         s;
        int         pick;
        int         ticks;
        three = 1'($urandom_range(0, 1));
        faces = three ? PRIMARY_USED : SLOT_COUNT_DEF;
        used = '0;
        push_beat(three ? OP_START_THREE : OP_START_FULL, t_pad'($urandom_range(0, 4095)));
        for (s = 0; s < faces; s++) begin
            if ($urandom_range(0, 5) == 0) push_noise();
            if ($urandom_range(0, 9) == 0)
                push_beat(OP_PAD, t_pad'(1) << $urandom_range(0, faces - 1));
            ticks = ($urandom_range(0, 4) == 0) ? $urandom_range(0, deb + 2) : deb;
            repeat (ticks) push_beat(OP_TICK, t_pad'($urandom_range(0, 4095)));
            do pick = $urandom_range(0, faces - 1);
            while (used[pick] && $urandom_range(0, 7) != 0);
            used[pick] = 1'b1;
            push_beat(OP_PAD, t_pad'(1) << pick);
            if ($urandom_range(0, 29) == 0) break;
        end
    endfunction

    // input and config driver
    int   tx_gap;
    int   settle_cnt;
    logic tx_burst;
    logic nxt_in_valid;
    logic nxt_cfg_valid;
    t_script_entry cur;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            cfg_ch.valid <= 1'b0;
            tx_gap = 0;
            settle_cnt = 0;
            tx_burst = 1'b0;
        end else begin
            nxt_in_valid = in_ch.valid;
            nxt_cfg_valid = cfg_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                predicted_beats.push_back(remap_step(in_ch.op, in_ch.pad_buttons));
                beats_sent++;
                nxt_in_valid = 1'b0;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                deb_ticks = cfg_ch.data;
                settings_done++;
                nxt_cfg_valid = 1'b0;
            end
            if (!nxt_in_valid && !nxt_cfg_valid) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                end else if (beat_script.size() == 0) begin
                    script_done = 1'b1;
                end else begin
                    cur = beat_script[0];
                    case (cur.kind)
                        SCRIPT_BEAT: begin
                            void'(beat_script.pop_front());
                            nxt_in_valid = 1'b1;
                            in_ch.op <= cur.op;
                            in_ch.pad_buttons <= cur.pad;
                            if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
                            tx_gap = tx_burst ? 0 : $urandom_range(0, 9);
                        end
                        SCRIPT_CFG: begin
                            void'(beat_script.pop_front());
                            nxt_cfg_valid = 1'b1;
                            cfg_ch.data <= cur.value;
                        end
                        default: begin
                            // hold off until every result is back and the block settles
                            if (predicted_beats.size() == 0) begin
                                settle_cnt++;
                                if (settle_cnt >= SETTLE_CYCLES) begin
                                    void'(beat_script.pop_front());
                                    settle_cnt = 0;
                                end
                            end else begin
                                settle_cnt = 0;
                            end
                        end
                    endcase
                end
            end
            in_ch.valid <= nxt_in_valid;
            cfg_ch.valid <= nxt_cfg_valid;
        end
    end

    // result monitor and receiver stalls
    int   rx_wait;
    int   rx_hold;
    logic rx_burst;
    t_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_wait = 0;
            rx_hold = 0;
            rx_burst = 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (predicted_beats.size() == 0) begin
                    report($sformatf("result %0d arrived with nothing predicted", results_seen));
                end else begin
                    want = predicted_beats.pop_front();
                    check_field("active", out_ch.active, want.active);
                    check_field("three_button_mode", out_ch.three_button_mode,
                                want.three_button_mode);
                    check_field("accepted", out_ch.accepted, want.accepted);
                    check_field("slot_index", out_ch.slot_index, want.slot_index);
                    check_field("button_code", out_ch.button_code, want.button_code);
                    check_field("finished", out_ch.finished, want.finished);
                    check_field("map_word", out_ch.map_word, want.map_word);
                end
                if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 9);
                // long back-pressure so the input side fills and stalls
                if (results_seen == 150 || results_seen == 1100) rx_hold = HOLD_CYCLES;
            end else if (rx_hold != 0) begin
                rx_hold--;
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            out_ch.ready <= (rx_hold == 0 && rx_wait == 0);
        end
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_cnt, predicted_beats.size());
        $display("Verification failed");
        $finish;
    end

    int deb_plan[6] = '{1, 0, 3, 2, 5, 1};
    int phase_end;
    int drain_cycles;

    initial begin
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_TICK;
        in_ch.pad_buttons = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        deb_ticks = DEBOUNCE_RESET;
        sess_on = 1'b0;
        three_on = 1'b0;
        next_slot = '0;
        deb_left = '0;
        for (int i = 0; i < SLOT_COUNT_DEF; i++) slot_map[i] = BTN_NONE;

        // reset-default debounce: a sample right after an assignment is ignored
        push_beat(OP_TICK, '0);
        push_beat(OP_PAD, 12'h001);
        push_beat(OP_START_FULL, '0);
        push_beat(OP_PAD, 12'h001);
        push_beat(OP_PAD, 12'h002);
        push_beat(OP_TICK, 12'hFFF);

        // no debounce: full session with rejects, then three-button sessions
        push_setting('0);
        push_beat(OP_START_FULL, 12'hFFF);
        push_beat(OP_PAD, 12'h000);
        push_beat(OP_PAD, 12'h003);
        push_beat(OP_PAD, 12'h040);
        push_beat(OP_PAD, 12'h800);
        push_beat(OP_PAD, 12'h001);
        push_beat(OP_PAD, 12'h001);
        push_beat(OP_PAD, 12'h002);
        push_beat(OP_PAD, 12'h004);
        push_beat(OP_PAD, 12'h008);
        push_beat(OP_PAD, 12'h010);
        push_beat(OP_PAD, 12'hFFF);
        push_beat(OP_PAD, 12'h020);
        push_beat(OP_PAD, 12'h001);
        push_beat(OP_START_THREE, '0);
        push_beat(OP_PAD, 12'h008);
        push_beat(OP_PAD, 12'h001);
        push_beat(OP_START_THREE, '0);
        push_beat(OP_PAD, 12'h002);
        push_beat(OP_PAD, 12'h002);
        push_beat(OP_PAD, 12'h004);
        push_beat(OP_PAD, 12'h001);

        // maximum debounce, cleared only by a restart
        push_setting(16'hFFFF);
        push_beat(OP_START_FULL, '0);
        push_beat(OP_PAD, 12'h001);
        push_beat(OP_PAD, 12'h002);
        push_beat(OP_TICK, '0);
        push_beat(OP_START_THREE, '0);
        push_beat(OP_PAD, 12'h004);

        foreach (deb_plan[p]) begin
            push_setting(t_deb'(deb_plan[p]));
            phase_end = beats_queued + PHASE_BEATS;
            while (beats_queued < phase_end) queue_session(deb_plan[p]);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!script_done) @(posedge i_clk);
        drain_cycles = 0;
        while (predicted_beats.size() != 0 && drain_cycles < 2000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (5) @(posedge i_clk);
        if (predicted_beats.size() != 0)
            report($sformatf("%0d predicted results never arrived", predicted_beats.size()));

        $display("covered %0d input beats and %0d result beats over %0d debounce settings",
                 beats_sent, results_seen, settings_done);
        $display("%0d buttons assigned, %0d sessions completed, %0d mismatches",
                 assigned_cnt, sessions_done, errors);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
